>>> rtl/pfx_pkg.sv
package pfx_pkg;

    localparam int DATA_W = 32;
    localparam int SYM_W = 8;
    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int ALU_STEPS = 32;
    localparam int STEP_W = $clog2(ALU_STEPS);

    localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic divz;
    } alu_stat_t;

    typedef struct packed {
        logic over;
        logic under;
        logic divz;
    } err_flags_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_RUN,
        ALU_FIX
    } alu_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RHS,
        S_GET_RHS,
        S_POP_LHS,
        S_GET_LHS,
        S_CALC,
        S_WAIT,
        S_PUSH,
        S_POP_END,
        S_GET_END,
        S_EMIT
    } pfx_state_t;

endpackage

>>> rtl/pfx_ram.sv
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pfx_alu.sv
module pfx_alu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pfx_pkg::alu_req_t          req,
    input  logic [pfx_pkg::DATA_W-1:0] lhs,
    input  logic [pfx_pkg::DATA_W-1:0] rhs,
    output pfx_pkg::alu_stat_t         status,
    output logic [pfx_pkg::DATA_W-1:0] result
);

    import pfx_pkg::*;

    alu_state_t         state_reg, state_next;
    alu_op_t            op_reg, op_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic               divz_reg, divz_next;
    logic               neg_reg, neg_next;
    logic [DATA_W-1:0]  a_reg, a_next;
    logic [DATA_W-1:0]  b_reg, b_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic [DATA_W-1:0]  res_reg, res_next;

    logic [DATA_W-1:0]  num_mag;
    logic [DATA_W-1:0]  den_mag;
    logic [DATA_W-1:0]  rem_shift;
    logic [DATA_W:0]    rem_diff;
    logic [DATA_W-1:0]  mul_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ALU_IDLE;
            done_reg  <= 1'b0;
            divz_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            divz_reg  <= divz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        num_mag   = lhs[DATA_W-1] ? (DATA_W'(0) - lhs) : lhs;
        den_mag   = rhs[DATA_W-1] ? (DATA_W'(0) - rhs) : rhs;
        rem_shift = {acc_reg[DATA_W-2:0], b_reg[DATA_W-1]};
        rem_diff  = {1'b0, rem_shift} - {1'b0, a_reg};
        mul_sum   = acc_reg + (b_reg[0] ? a_reg : DATA_W'(0));

        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        divz_next  = divz_reg;
        neg_next   = neg_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;

        unique case (state_reg)
            ALU_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    cnt_next   = STEP_W'(ALU_STEPS - 1);
                    divz_next  = 1'b0;
                    neg_next   = 1'b0;
                    acc_next   = '0;
                    a_next     = lhs;
                    b_next     = rhs;
                    state_next = ALU_RUN;
                    if (req.op == OP_DIV)
                    begin
                        a_next   = den_mag;
                        b_next   = num_mag;
                        neg_next = lhs[DATA_W-1] ^ rhs[DATA_W-1];
                        if (den_mag == '0)
                        begin
                            divz_next  = 1'b1;
                            neg_next   = 1'b0;
                            b_next     = '0;
                            state_next = ALU_FIX;
                        end
                    end
                end
            end
            ALU_RUN:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        res_next   = a_reg + b_reg;
                        done_next  = 1'b1;
                        state_next = ALU_IDLE;
                    end
                    OP_SUB:
                    begin
                        res_next   = a_reg - b_reg;
                        done_next  = 1'b1;
                        state_next = ALU_IDLE;
                    end
                    OP_MUL:
                    begin
                        acc_next = mul_sum;
                        a_next   = {a_reg[DATA_W-2:0], 1'b0};
                        b_next   = {1'b0, b_reg[DATA_W-1:1]};
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == '0)
                        begin
                            res_next   = mul_sum;
                            done_next  = 1'b1;
                            state_next = ALU_IDLE;
                        end
                    end
                    OP_DIV:
                    begin
                        acc_next = rem_diff[DATA_W] ? rem_shift : rem_diff[DATA_W-1:0];
                        b_next   = {b_reg[DATA_W-2:0], ~rem_diff[DATA_W]};
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == '0)
                        begin
                            state_next = ALU_FIX;
                        end
                    end
                endcase
            end
            ALU_FIX:
            begin
                res_next   = neg_reg ? (DATA_W'(0) - b_reg) : b_reg;
                done_next  = 1'b1;
                state_next = ALU_IDLE;
            end
            default:
            begin
                state_next = ALU_IDLE;
            end
        endcase
    end

    assign status.done = done_reg;
    assign status.divz = divz_reg;
    assign result      = res_reg;

endmodule

>>> rtl/postfix_expression_evaluator.sv
// Evaluates a postfix expression fed one character per request on the symbol channel and
// returns one result request per NUL character, carrying the final value and the sticky
// overflow, underflow and divide-by-zero flags. A NUL waits for the result channel to drain
// before its result is raised. Multiply and divide run through one shared unit that retires
// one bit per cycle, and each pop is split into a pop state and a get state because the
// operand stack is a memory with separate read and write ports and a registered read.
// Symbol_ready is high only while the sequencer is idle.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              symbol_valid,
    output logic                              symbol_ready,
    input  logic [pfx_pkg::SYM_W-1:0]         symbol,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [pfx_pkg::DATA_W-1:0] value,
    output logic                              overflowed,
    output logic                              underflowed,
    output logic                              divided_by_zero
);

    import pfx_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    pfx_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    err_flags_t        flags_reg, flags_next;
    logic              result_valid_reg, result_valid_next;
    err_flags_t        out_flags_reg, out_flags_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    alu_op_t           op_reg, op_next;
    logic              empty_reg, empty_next;
    logic [DATA_W-1:0] lhs_reg, lhs_next;
    logic [DATA_W-1:0] rhs_reg, rhs_next;
    logic [DATA_W-1:0] push_reg, push_next;

    logic              ram_we;
    logic [CW-1:0]     count_dec;
    logic [DATA_W-1:0] ram_rdata;
    logic              stack_empty;
    logic              stack_full;
    alu_req_t          alu_req;
    alu_stat_t         alu_stat;
    logic [DATA_W-1:0] alu_result;

    pfx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (push_reg),
        .raddr (count_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    pfx_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .lhs    (lhs_reg),
        .rhs    (rhs_reg),
        .status (alu_stat),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            flags_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            flags_reg        <= flags_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_flags_reg <= out_flags_next;
        out_value_reg <= out_value_next;
        op_reg        <= op_next;
        empty_reg     <= empty_next;
        lhs_reg       <= lhs_next;
        rhs_reg       <= rhs_next;
        push_reg      <= push_next;
    end

    assign count_dec   = count_reg - 1'b1;
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CW'(STACK_DEPTH));

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        flags_next        = flags_reg;
        result_valid_next = result_valid_reg;
        out_flags_next    = out_flags_reg;
        out_value_next    = out_value_reg;
        op_next           = op_reg;
        empty_next        = empty_reg;
        lhs_next          = lhs_reg;
        rhs_next          = rhs_reg;
        push_next         = push_reg;
        ram_we            = 1'b0;
        alu_req.start     = 1'b0;
        alu_req.op        = op_reg;
        symbol_ready      = 1'b0;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                symbol_ready = 1'b1;
                if (symbol_valid)
                begin
                    unique case (symbol)
                        CHAR_NUL:   state_next = S_POP_END;
                        CHAR_PLUS:
                        begin
                            op_next    = OP_ADD;
                            state_next = S_POP_RHS;
                        end
                        CHAR_MINUS:
                        begin
                            op_next    = OP_SUB;
                            state_next = S_POP_RHS;
                        end
                        CHAR_STAR:
                        begin
                            op_next    = OP_MUL;
                            state_next = S_POP_RHS;
                        end
                        CHAR_SLASH:
                        begin
                            op_next    = OP_DIV;
                            state_next = S_POP_RHS;
                        end
                        default:
                        begin
                            push_next  = DATA_W'(symbol) - DATA_W'(CHAR_ZERO);
                            state_next = S_PUSH;
                        end
                    endcase
                end
            end
            S_POP_RHS, S_POP_LHS, S_POP_END:
            begin
                empty_next = stack_empty;
                if (stack_empty)
                begin
                    flags_next.under = 1'b1;
                end
                else
                begin
                    count_next = count_dec;
                end
                unique case (state_reg)
                    S_POP_RHS: state_next = S_GET_RHS;
                    S_POP_LHS: state_next = S_GET_LHS;
                    default:   state_next = S_GET_END;
                endcase
            end
            S_GET_RHS:
            begin
                rhs_next   = empty_reg ? '0 : ram_rdata;
                state_next = S_POP_LHS;
            end
            S_GET_LHS:
            begin
                lhs_next   = empty_reg ? '0 : ram_rdata;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                alu_req.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_stat.done)
                begin
                    push_next       = alu_result;
                    flags_next.divz = flags_reg.divz | alu_stat.divz;
                    state_next      = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (stack_full)
                begin
                    flags_next.over = 1'b1;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            S_GET_END:
            begin
                push_next  = empty_reg ? '0 : ram_rdata;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    out_value_next    = push_reg;
                    out_flags_next    = flags_reg;
                    count_next        = '0;
                    flags_next        = '0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result_valid    = result_valid_reg;
    assign value           = $signed(out_value_reg);
    assign overflowed      = out_flags_reg.over;
    assign underflowed     = out_flags_reg.under;
    assign divided_by_zero = out_flags_reg.divz;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("Stack count exceeds the stack depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !stack_full && state_reg == S_PUSH)
        else $error("Stack write while the stack is full or outside a push.");

    assert property (@(posedge clk) disable iff (!rst_n)
        alu_stat.done |-> state_reg == S_WAIT)
        else $error("Arithmetic unit finished while the sequencer was not waiting.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("Result raised outside the end of an expression.");

endmodule
